/* sv/drp_pkg.sv */
// drp_pkg: shared types, character codes and sizes for the delimited record parser
// used by drp_front, drp_queue, drp_back and delimited_record_parser_top
`default_nettype none

package drp_pkg;

	// width of the saturating field counter inside the parser
	localparam int FIELD_COUNT_BITS = 16;
	// run queue depth between front and back, a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_BITS = QPTR_BITS + 1;

	localparam logic [7:0] QUOTE_CH    = 8'h22;
	localparam logic [7:0] LF_CH       = 8'h0A;
	localparam logic [7:0] CR_CH       = 8'h0D;
	localparam logic [7:0] DELIM_RESET = 8'd44;

	typedef logic [FIELD_COUNT_BITS-1:0] fcount_t;

	// one result item
	typedef struct packed {
		logic [7:0]  data;
		logic        valid;
		logic        fdone;
		logic        rdone;
		logic [15:0] fnum;
		logic        header;
	} result_t;

	// all results caused by one input item (one or two)
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} entry_t;

	// build one result, content byte forced to zero when not valid
	function automatic result_t make_result(input logic [7:0] b, input logic v,
		input logic fd, input logic rd, input fcount_t cnt, input logic hdr);
		result_t r;
		r.data   = v ? b : 8'h00;
		r.valid  = v;
		r.fdone  = fd;
		r.rdone  = rd;
		r.fnum   = 16'(cnt);
		r.header = hdr;
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/delimited_record_parser_top.sv */
// Delimited record parser: one text byte per cycle in, up to two result items out per
// byte (content byte, field end, record end), one result item per cycle out while
// out_ready is high. The front takes a byte every cycle while the four-entry run queue
// has room; the output drains one result per cycle while out_ready is high, so a
// sustained rate of one byte per cycle holds whenever bytes cause at most one result on
// average. A byte causing two results is a delimiter or content byte with final_byte
// set. Results pass a queue slot, then the output register. The delimiter register may
// be written only while the block is idle. Depends on drp_pkg and the drp_* modules.
`default_nettype none

module delimited_record_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             field_done,
	output logic             record_done,
	output logic [15:0]      field_number,
	output logic             header_record,
	output logic             last_of_run
);

	logic             q_ready, q_push, q_not_empty, q_pop;
	drp_pkg::entry_t  q_entry, q_head;
	drp_pkg::result_t res;

	// parser front
	drp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	// run queue
	drp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.not_full   (q_ready),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// output back
	drp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_res     (res),
		.out_last    (last_of_run)
	);

	// result fields onto ports
	assign out_byte      = res.data;
	assign byte_valid    = res.valid;
	assign field_done    = res.fdone;
	assign record_done   = res.rdone;
	assign field_number  = res.fnum;
	assign header_record = res.header;

endmodule

`default_nettype wire

/* sv/drp_front.sv */
// drp_front: accepts text bytes, tracks quoting and field/record state,
// and produces the run of results for each byte; depends on drp_pkg
`default_nettype none

module drp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [7:0]       cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       data_byte,
	input  wire logic             final_byte,
	input  wire logic             q_ready,
	output logic                  q_push,
	output drp_pkg::entry_t       q_entry
);

	logic [7:0]       delim_q;
	logic             inq_q, cqp_q, swl_q, afs_q, fhb_q, open_q, hs_q;
	drp_pkg::fcount_t cnt_q;

	logic             n_inq, n_cqp, n_swl, n_afs, n_fhb, n_open, n_hs;
	drp_pkg::fcount_t n_cnt;
	drp_pkg::result_t res [2];
	logic [1:0]       n_res;
	logic             skip, do_unq, do_content, blank;
	logic             accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	// per-byte parse: next state and up to two results
	always_comb begin
		n_inq = inq_q;
		n_cqp = cqp_q;
		n_swl = 1'b0;
		n_afs = afs_q;
		n_fhb = fhb_q;
		n_open = open_q;
		n_hs = hs_q;
		n_cnt = cnt_q;
		res[0] = '0;
		res[1] = '0;
		n_res = 2'd0;
		do_unq = 1'b0;
		do_content = 1'b0;
		blank = 1'b0;
		skip = swl_q && (data_byte == drp_pkg::LF_CH);

		// classify the byte
		if (!skip) begin
			n_open = 1'b1;
			if (cqp_q) begin
				n_cqp = 1'b0;
				if (data_byte == drp_pkg::QUOTE_CH) begin
					do_content = 1'b1;
				end else begin
					n_inq = 1'b0;
					do_unq = 1'b1;
				end
			end else if (afs_q && data_byte == drp_pkg::QUOTE_CH) begin
				n_inq = 1'b1;
				n_afs = 1'b0;
			end else if (inq_q) begin
				if (data_byte == drp_pkg::QUOTE_CH)
					n_cqp = 1'b1;
				else
					do_content = 1'b1;
			end else begin
				do_unq = 1'b1;
			end
		end

		// unquoted text: delimiter first, then line ends, else content
		if (do_unq) begin
			if (data_byte == delim_q) begin
				res[n_res[0]] = drp_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b0, n_cnt, !n_hs);
				n_res = n_res + 2'd1;
				if (n_cnt != {drp_pkg::FIELD_COUNT_BITS{1'b1}})
					n_cnt = n_cnt + 1'b1;
				n_afs = 1'b1;
				n_fhb = 1'b0;
			end else if (data_byte == drp_pkg::CR_CH || data_byte == drp_pkg::LF_CH) begin
				blank = n_hs && (n_cnt == '0) && !n_fhb;
				if (!blank) begin
					res[n_res[0]] = drp_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b1, n_cnt,
						!n_hs);
					n_res = n_res + 2'd1;
				end
				n_hs = 1'b1;
				n_inq = 1'b0;
				n_cqp = 1'b0;
				n_afs = 1'b1;
				n_fhb = 1'b0;
				n_cnt = '0;
				n_open = 1'b0;
				n_swl = (data_byte == drp_pkg::CR_CH);
			end else begin
				do_content = 1'b1;
			end
		end

		// content byte
		if (do_content) begin
			res[n_res[0]] = drp_pkg::make_result(data_byte, 1'b1, 1'b0, 1'b0, n_cnt, !n_hs);
			n_res = n_res + 2'd1;
			n_afs = 1'b0;
			n_fhb = 1'b1;
		end

		// end of buffer closes an open record, then everything restarts
		if (final_byte) begin
			if (n_open) begin
				blank = n_hs && (n_cnt == '0) && !n_fhb;
				if (!blank) begin
					res[n_res[0]] = drp_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b1, n_cnt,
						!n_hs);
					n_res = n_res + 2'd1;
				end
			end
			n_inq = 1'b0;
			n_cqp = 1'b0;
			n_swl = 1'b0;
			n_afs = 1'b1;
			n_fhb = 1'b0;
			n_cnt = '0;
			n_open = 1'b0;
			n_hs = 1'b0;
		end
	end

	assign q_push        = accept && (n_res != 2'd0);
	assign q_entry.two    = (n_res == 2'd2);
	assign q_entry.first  = res[0];
	assign q_entry.second = res[1];

	// delimiter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			delim_q <= drp_pkg::DELIM_RESET;
		else if (cfg_wr_en)
			delim_q <= cfg_wr_data;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inq_q <= 1'b0;
			cqp_q <= 1'b0;
			swl_q <= 1'b0;
			afs_q <= 1'b1;
			fhb_q <= 1'b0;
			cnt_q <= '0;
			open_q <= 1'b0;
			hs_q <= 1'b0;
		end else if (accept) begin
			inq_q <= n_inq;
			cqp_q <= n_cqp;
			swl_q <= n_swl;
			afs_q <= n_afs;
			fhb_q <= n_fhb;
			cnt_q <= n_cnt;
			open_q <= n_open;
			hs_q <= n_hs;
		end
	end

	// a pending closing quote only exists inside a quoted field
	a_cqp_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		cqp_q |-> inq_q) else $error("closing quote pending outside quoted field");

	// a closed record never carries a field count
	a_closed_count: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (cnt_q == '0)) else $error("field count left over after record close");

endmodule

`default_nettype wire

/* sv/drp_queue.sv */
// drp_queue: short queue of result runs between parser front and output back
// depends on drp_pkg
`default_nettype none

module drp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  drp_pkg::entry_t       push_entry,
	output logic                  not_full,
	input  wire logic             pop,
	output logic                  not_empty,
	output drp_pkg::entry_t       head
);

	drp_pkg::entry_t                  slot_q [drp_pkg::QUEUE_DEPTH];
	logic [drp_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [drp_pkg::QCOUNT_BITS-1:0] count_q;

	assign not_full  = (count_q != drp_pkg::QCOUNT_BITS'(drp_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full) else $error("push into full run queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty run queue");

endmodule

`default_nettype wire

/* sv/drp_back.sv */
// drp_back: takes result runs off the queue and sends them out one result
// at a time through an output register; depends on drp_pkg
`default_nettype none

module drp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_not_empty,
	input  drp_pkg::entry_t       q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output drp_pkg::result_t      out_res,
	output logic                  out_last
);

	logic             sel_q;
	logic             out_valid_q;
	drp_pkg::result_t out_res_q;
	logic             out_last_q;
	logic             load, last_sel;

	assign load     = q_not_empty && (!out_valid_q || out_ready);
	assign last_sel = sel_q || !q_head.two;
	assign q_pop    = load && last_sel;

	// second-result select within the head run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (load)
			sel_q <= !last_sel;
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= sel_q ? q_head.second : q_head.first;
			out_last_q <= last_sel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

	// the second half of a run is only selected while that run is at the head
	a_sel_head: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (q_not_empty && q_head.two)) else $error("second result selected without run");

endmodule

`default_nettype wire
